### src/voxel_occupancy_pyramid_assert.svh
// assertion macros for the voxel occupancy pyramid checker
// expects clk and rst to be visible where the macros are used
`ifndef VOXEL_OCCUPANCY_PYRAMID_ASSERT_SVH
`define VOXEL_OCCUPANCY_PYRAMID_ASSERT_SVH

// checked only outside reset
`define VOP_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define VOP_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/vop_pkg.sv
// shared types and constants for the voxel occupancy pyramid
// no dependencies
package vop_pkg;

  localparam int LEVELS_DEF = 6;

  localparam int FUNC_W  = 2;
  localparam int COORD_W = 6;
  localparam int VALUE_W = 32;
  localparam int QLVL_W  = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_MARK,
    ST_QREAD,
    ST_QWAIT,
    ST_DONE
  } state_t;

  // memory command from the sequencer
  typedef struct packed {
    logic wr;
    logic rd;
    logic wr_bit;
    logic sweep;
  } mem_ctl_t;

endpackage

### src/vop_index.sv
// cell address unit: flat store address of one cell at a given level
// depends on vop_pkg
module vop_index #(
  parameter int LEVELS = vop_pkg::LEVELS_DEF,
  parameter int LVL_W  = 3,
  parameter int ADDR_W = 16
) (
  input  logic [LVL_W-1:0]          level,
  input  logic [vop_pkg::COORD_W-1:0] x,
  input  logic [vop_pkg::COORD_W-1:0] y,
  input  logic [vop_pkg::COORD_W-1:0] z,
  output logic [ADDR_W-1:0]         addr
);
  import vop_pkg::*;

  localparam int KEY_W = 3 * LEVELS;

  logic [LEVELS-1:0] fx, fy, fz;
  logic [LEVELS-1:0] cx, cy, cz;
  logic [LVL_W-1:0]  sh;
  logic [LVL_W:0]    lvl2;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  base;
  logic [KEY_W-1:0]  sum;

  // full resolution coordinate, LEVELS bits wide
  if (LEVELS >= COORD_W) begin : g_ext
    assign fx = LEVELS'(x);
    assign fy = LEVELS'(y);
    assign fz = LEVELS'(z);
  end else begin : g_trunc
    assign fx = x[LEVELS-1:0];
    assign fy = y[LEVELS-1:0];
    assign fz = z[LEVELS-1:0];
  end

  assign sh   = LVL_W'(LEVELS) - level;
  assign lvl2 = {level, 1'b0};
  assign cx   = fx >> sh;
  assign cy   = fy >> sh;
  assign cz   = fz >> sh;

  // coordinates occupy disjoint bit fields of the level's key
  assign key = KEY_W'(cx) | (KEY_W'(cy) << level) | (KEY_W'(cz) << lvl2);

  // level base offset is 8^0 + 8^1 + ... below this level: one bit per octal digit
  always_comb begin
    base = '0;
    for (int i = 0; i < LEVELS; i++) begin
      base[3*i] = (LVL_W'(i) < level);
    end
  end

  assign sum  = base + key;
  assign addr = sum[ADDR_W-1:0];

endmodule

### src/vop_store.sv
// single bit wide occupancy memory, one write and one registered read per cycle
// depends on vop_pkg for the command struct
module vop_store #(
  parameter int DEPTH  = 37449,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  vop_pkg::mem_ctl_t ctl,
  input  logic [ADDR_W-1:0] addr,
  output logic              rd_bit
);
  import vop_pkg::*;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= ctl.wr_bit;
    end
    if (ctl.rd) begin
      rd_bit <= mem[addr];
    end
  end

endmodule

### src/vop_seq.sv
// sequencer: takes one transaction at a time, steps levels or sweeps the store,
// and holds the result register; depends on vop_pkg
module vop_seq #(
  parameter int LEVELS     = vop_pkg::LEVELS_DEF,
  parameter int LVL_W      = 3,
  parameter int ADDR_W     = 16,
  parameter int CELL_TOTAL = 37449
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [vop_pkg::FUNC_W-1:0]  func,
  input  logic [vop_pkg::COORD_W-1:0] vx,
  input  logic [vop_pkg::COORD_W-1:0] vy,
  input  logic [vop_pkg::COORD_W-1:0] vz,
  input  logic [vop_pkg::VALUE_W-1:0] voxel_value,
  input  logic [vop_pkg::QLVL_W-1:0]  query_level,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic                        occupied,
  output logic [LVL_W-1:0]            level,
  output logic [vop_pkg::COORD_W-1:0] x,
  output logic [vop_pkg::COORD_W-1:0] y,
  output logic [vop_pkg::COORD_W-1:0] z,
  output logic [ADDR_W-1:0]           sweep,
  output vop_pkg::mem_ctl_t           ctl,
  input  logic                        rd_bit
);
  import vop_pkg::*;

  state_t state, state_next;
  func_t  fcode;
  logic   res;
  logic   accept;
  logic   rsp_free;
  logic   last_sweep;
  logic   last_level;
  logic   value_nz;
  logic   qlvl_ok;

  assign fcode      = func_t'(func);
  assign req_ready  = (state == ST_IDLE);
  assign accept     = req_valid && req_ready;
  assign rsp_free   = !rsp_valid || rsp_ready;
  assign last_sweep = (sweep == ADDR_W'(CELL_TOTAL - 1));
  assign last_level = (level == LVL_W'(LEVELS - 1));
  assign value_nz   = (voxel_value != '0);
  assign qlvl_ok    = ({1'b0, query_level} < (QLVL_W + 1)'(LEVELS));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (last_sweep) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          unique case (fcode)
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_MARK:  state_next = value_nz ? ST_MARK : ST_DONE;
            FUNC_QUERY: state_next = qlvl_ok ? ST_QREAD : ST_DONE;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (last_sweep) state_next = ST_DONE;
      end
      ST_MARK: begin
        if (last_level) state_next = ST_DONE;
      end
      ST_QREAD: state_next = ST_QWAIT;
      ST_QWAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        ctl.wr    = 1'b1;
        ctl.sweep = 1'b1;
      end
      ST_MARK: begin
        ctl.wr     = 1'b1;
        ctl.wr_bit = 1'b1;
      end
      ST_QREAD: ctl.rd = 1'b1;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_CLEAR) begin
        sweep <= last_sweep ? '0 : sweep + 1'b1;
      end
      if (state == ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x     <= vx;
      y     <= vy;
      z     <= vz;
      res   <= 1'b0;
      level <= (fcode == FUNC_QUERY) ? LVL_W'(query_level) : '0;
    end else if (state == ST_MARK) begin
      level <= level + 1'b1;
    end else if (state == ST_QWAIT) begin
      res <= rd_bit;
    end
    if (state == ST_DONE && rsp_free) begin
      occupied <= res;
    end
  end

endmodule

### src/voxel_occupancy_pyramid.sv
// channel   signals                                          handshake
// request   func vx vy vz voxel_value query_level            req_valid / req_ready
// response  occupied                                         rsp_valid / rsp_ready
//
// mark: one store write per level, none when voxel_value is zero
// query: answered from the registered read of the single port store
// clear: one cell cleared per cycle over CELL_TOTAL cells (37449 at LEVELS = 6)
// after reset the same sweep runs over all CELL_TOTAL cells with req_ready low
// a finished result waits in the output register; the next request is taken meanwhile
//
// top level; depends on vop_pkg, vop_index, vop_store, vop_seq
module voxel_occupancy_pyramid #(
  parameter int LEVELS = vop_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [vop_pkg::FUNC_W-1:0]  func,
  input  logic [vop_pkg::COORD_W-1:0] vx,
  input  logic [vop_pkg::COORD_W-1:0] vy,
  input  logic [vop_pkg::COORD_W-1:0] vz,
  input  logic [vop_pkg::VALUE_W-1:0] voxel_value,
  input  logic [vop_pkg::QLVL_W-1:0]  query_level,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic                        occupied
);
  import vop_pkg::*;

  localparam int LVL_W      = $clog2(LEVELS + 1);
  localparam int ADDR_W     = 3 * LEVELS - 2;
  localparam int CELL_TOTAL = int'(((64'd1 << (3 * LEVELS)) - 64'd1) / 64'd7);

  logic [LVL_W-1:0]   level;
  logic [COORD_W-1:0] x, y, z;
  logic [ADDR_W-1:0]  sweep;
  logic [ADDR_W-1:0]  idx_addr;
  logic [ADDR_W-1:0]  mem_addr;
  mem_ctl_t           ctl;
  logic               rd_bit;

  vop_seq #(
    .LEVELS     (LEVELS),
    .LVL_W      (LVL_W),
    .ADDR_W     (ADDR_W),
    .CELL_TOTAL (CELL_TOTAL)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .func        (func),
    .vx          (vx),
    .vy          (vy),
    .vz          (vz),
    .voxel_value (voxel_value),
    .query_level (query_level),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .occupied    (occupied),
    .level       (level),
    .x           (x),
    .y           (y),
    .z           (z),
    .sweep       (sweep),
    .ctl         (ctl),
    .rd_bit      (rd_bit)
  );

  vop_index #(
    .LEVELS (LEVELS),
    .LVL_W  (LVL_W),
    .ADDR_W (ADDR_W)
  ) u_index (
    .level (level),
    .x     (x),
    .y     (y),
    .z     (z),
    .addr  (idx_addr)
  );

  assign mem_addr = ctl.sweep ? sweep : idx_addr;

  vop_store #(
    .DEPTH  (CELL_TOTAL),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk    (clk),
    .ctl    (ctl),
    .addr   (mem_addr),
    .rd_bit (rd_bit)
  );

endmodule

### src/vop_checker.sv
// port level checks for voxel_occupancy_pyramid, bound to the top level
// depends on voxel_occupancy_pyramid_assert.svh
`include "voxel_occupancy_pyramid_assert.svh"

module vop_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic occupied
);

  // store sweep after reset keeps requests out
  `VOP_ASSERT_ALL(a_ready_low_after_reset, rst |=> !req_ready, "req_ready high after reset")

  // one transaction in work at a time
  `VOP_ASSERT_RUN(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "ready after accept")

  `VOP_ASSERT_RUN(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped")

  `VOP_ASSERT_RUN(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(occupied), "occupied changed")

endmodule

bind voxel_occupancy_pyramid vop_checker u_vop_checker (.*);
